### hw/rtl/ffa_pkg.sv
`timescale 1ns / 1ps
// Shared request, response, status and control types for the first-fit allocator.
package ffa_pkg;

  localparam int SIZE_W  = 17;
  localparam int ADDR_W  = 16;
  localparam int TOTAL_W = 17;

  localparam logic [TOTAL_W-1:0] TOTAL_RST = 17'h10000;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_NOFIT  = 3'd1,
    ST_FULL   = 3'd2,
    ST_ZERO   = 3'd3,
    ST_NOADDR = 3'd4
  } status_t;

  typedef struct packed {
    logic              opcode;
    logic [SIZE_W-1:0] alloc_size;
    logic [ADDR_W-1:0] address;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [ADDR_W-1:0] start_address;
  } rsp_t;

  typedef struct packed {
    logic    seed;
    logic    cfg_load;
    logic    accept;
    logic    scan_mode;
    logic    wr_used;
    logic    shift_init;
    logic    shift_mode;
    logic    wr_hi;
    logic    wr_lo;
    logic    comp_mode;
    logic    comp_last;
    logic    out_load;
    status_t res;
  } cmd_t;

  typedef struct packed {
    logic req_free;
    logic req_zero;
    logic fit;
    logic exact;
    logic full;
    logic asc_done;
    logic dsc_done;
    logic found;
    logic out_room;
  } sts_t;

endpackage

### hw/rtl/ffa_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for seeding, allocate scan and split, free with merge, and response hand-off.
module ffa_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  ffa_pkg::sts_t sts,
  output ffa_pkg::cmd_t cmd
);
  import ffa_pkg::*;

  typedef enum logic [10:0] {
    S_SEED  = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_DISP  = 11'b00000000100,
    S_ASCAN = 11'b00000001000,
    S_AFIT  = 11'b00000010000,
    S_SHIFT = 11'b00000100000,
    S_SPLHI = 11'b00001000000,
    S_SPLLO = 11'b00010000000,
    S_FSCAN = 11'b00100000000,
    S_FLAST = 11'b01000000000,
    S_RESP  = 11'b10000000000
  } state_t;

  state_t  state_r, state_nxt;
  status_t res_r, res_nxt;

  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    cmd       = '0;
    cmd.res   = res_r;
    in_stall  = 1'b1;
    cfg_ready = 1'b0;
    unique case (state_r)
      S_SEED: begin
        cmd.seed  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        cfg_ready = 1'b1;
        in_stall  = cfg_valid;
        priority if (cfg_valid) begin
          cmd.cfg_load = 1'b1;
          state_nxt    = S_SEED;
        end else if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DISP;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DISP: begin
        priority if (sts.req_free) begin
          state_nxt = S_FSCAN;
        end else if (sts.req_zero) begin
          res_nxt   = ST_ZERO;
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_ASCAN;
        end
      end
      S_ASCAN: begin
        cmd.scan_mode = 1'b1;
        priority if (sts.fit) begin
          state_nxt = S_AFIT;
        end else if (sts.asc_done) begin
          res_nxt   = ST_NOFIT;
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_ASCAN;
        end
      end
      S_AFIT: begin
        priority if (sts.exact) begin
          cmd.wr_used = 1'b1;
          res_nxt     = ST_OK;
          state_nxt   = S_RESP;
        end else if (sts.full) begin
          res_nxt   = ST_FULL;
          state_nxt = S_RESP;
        end else begin
          cmd.shift_init = 1'b1;
          state_nxt      = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd.shift_mode = 1'b1;
        if (sts.dsc_done) begin
          state_nxt = S_SPLHI;
        end
      end
      S_SPLHI: begin
        cmd.wr_hi = 1'b1;
        state_nxt = S_SPLLO;
      end
      S_SPLLO: begin
        cmd.wr_lo = 1'b1;
        res_nxt   = ST_OK;
        state_nxt = S_RESP;
      end
      S_FSCAN: begin
        cmd.comp_mode = 1'b1;
        if (sts.asc_done) begin
          state_nxt = S_FLAST;
        end
      end
      S_FLAST: begin
        cmd.comp_last = 1'b1;
        res_nxt       = sts.found ? ST_OK : ST_NOADDR;
        state_nxt     = S_RESP;
      end
      S_RESP: begin
        if (sts.out_room) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_SEED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SEED;
      res_r   <= ST_OK;
    end else begin
      state_r <= state_nxt;
      res_r   <= res_nxt;
    end
  end

endmodule

### hw/rtl/ffa_dp.sv
`timescale 1ns / 1ps
// Segment table memory, scan and merge pointers, split arithmetic and response register.
module ffa_dp #(
  parameter int MAX_SEGMENTS = 64,
  parameter int ADDR_BITS    = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ffa_pkg::cmd_t                 cmd,
  output ffa_pkg::sts_t                 sts,
  input  ffa_pkg::req_t                 in_data,
  input  logic [ffa_pkg::TOTAL_W-1:0]   cfg_data,
  input  logic                          out_stall,
  output logic                          out_valid,
  output ffa_pkg::rsp_t                 out_data
);
  import ffa_pkg::*;

  localparam int IW    = $clog2(MAX_SEGMENTS);
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int AW    = ADDR_BITS;
  localparam int SW    = ADDR_BITS + 1;
  localparam int CW    = (SW > SIZE_W) ? SW : SIZE_W;
  localparam int MW    = (AW > ADDR_W) ? AW : ADDR_W;

  localparam logic [CW-1:0]    SPACE   = CW'(64'd1 << AW);
  localparam logic [MW-1:0]    AMASK   = MW'((64'd1 << AW) - 64'd1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SEGMENTS);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  typedef struct packed {
    logic [AW-1:0] start;
    logic [SW-1:0] size;
    logic          free;
  } ent_t;

  ent_t mem [MAX_SEGMENTS];

  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0]   ridx_r;
  logic [CNT_W-1:0]   hit_idx_r;
  logic               rvld_r;
  ent_t               rdata_r;
  ent_t               hit_r;
  req_t               req_r;
  ent_t               acc_r, acc_nxt;
  logic               acc_vld_r, acc_vld_nxt;
  logic               found_r, found_nxt;
  logic               out_vld_r, out_vld_nxt;
  rsp_t               out_r, out_nxt;

  logic               rd_en;
  logic [IW-1:0]      rd_addr;
  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  ent_t               wr_ent;
  logic               asc_more;
  logic               dsc_more;
  logic               fit;
  logic               hit_now;
  logic               match;
  logic               comp_wr;
  ent_t               cur;
  logic [CW-1:0]      seed_sz;
  logic [CNT_W-1:0]   ridx_plus;
  logic [CNT_W-1:0]   hit_plus;

  assign asc_more  = rd_ptr_r < count_r;
  assign dsc_more  = rd_ptr_r > hit_idx_r;
  assign rd_en     = ((cmd.scan_mode || cmd.comp_mode) && asc_more) ||
                     (cmd.shift_mode && dsc_more);
  assign rd_addr   = rd_ptr_r[IW-1:0];
  assign ridx_plus = ridx_r + CNT_ONE;
  assign hit_plus  = hit_idx_r + CNT_ONE;
  assign fit       = rvld_r && rdata_r.free &&
                     (CW'(rdata_r.size) >= CW'(req_r.alloc_size));
  assign hit_now   = cmd.scan_mode && fit;
  assign match     = (MW'(rdata_r.start) == (MW'(req_r.address) & AMASK));
  assign seed_sz   = (CW'(total_r) > SPACE) ? SPACE : CW'(total_r);
  assign total_nxt = cmd.cfg_load ? cfg_data : total_r;

  always_comb begin
    cur      = rdata_r;
    cur.free = rdata_r.free | match;
  end

  always_comb begin
    priority if (cmd.accept) begin
      rd_ptr_nxt = '0;
    end else if (cmd.shift_init) begin
      rd_ptr_nxt = count_r - CNT_ONE;
    end else if (rd_en && cmd.shift_mode) begin
      rd_ptr_nxt = rd_ptr_r - CNT_ONE;
    end else if (rd_en) begin
      rd_ptr_nxt = rd_ptr_r + CNT_ONE;
    end else begin
      rd_ptr_nxt = rd_ptr_r;
    end
  end

  // merge pass: fold each returned entry into the pending one, flush on a break
  always_comb begin
    acc_nxt     = acc_r;
    acc_vld_nxt = acc_vld_r;
    found_nxt   = found_r;
    wr_ptr_nxt  = wr_ptr_r;
    comp_wr     = 1'b0;
    if (cmd.accept) begin
      acc_vld_nxt = 1'b0;
      found_nxt   = 1'b0;
      wr_ptr_nxt  = '0;
    end else if (cmd.comp_mode && rvld_r) begin
      found_nxt = found_r | match;
      priority if (!acc_vld_r) begin
        acc_nxt     = cur;
        acc_vld_nxt = 1'b1;
      end else if (acc_r.free && cur.free) begin
        acc_nxt.size = acc_r.size + cur.size;
      end else begin
        comp_wr    = 1'b1;
        wr_ptr_nxt = wr_ptr_r + CNT_ONE;
        acc_nxt    = cur;
      end
    end
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = '0;
    wr_ent  = '0;
    priority if (cmd.seed) begin
      wr_ent.size = SW'(seed_sz);
      wr_ent.free = 1'b1;
    end else if (cmd.wr_used) begin
      wr_addr     = hit_idx_r[IW-1:0];
      wr_ent      = hit_r;
      wr_ent.free = 1'b0;
    end else if (cmd.shift_mode && rvld_r) begin
      wr_addr = ridx_plus[IW-1:0];
      wr_ent  = rdata_r;
    end else if (cmd.wr_hi) begin
      wr_addr      = hit_plus[IW-1:0];
      wr_ent.start = hit_r.start + AW'(req_r.alloc_size);
      wr_ent.size  = hit_r.size - SW'(req_r.alloc_size);
      wr_ent.free  = 1'b1;
    end else if (cmd.wr_lo) begin
      wr_addr      = hit_idx_r[IW-1:0];
      wr_ent.start = hit_r.start;
      wr_ent.size  = SW'(req_r.alloc_size);
      wr_ent.free  = 1'b0;
    end else if (comp_wr || cmd.comp_last) begin
      wr_addr = wr_ptr_r[IW-1:0];
      wr_ent  = acc_r;
    end else begin
      wr_en = 1'b0;
    end
  end

  always_comb begin
    priority if (cmd.seed) begin
      count_nxt = CNT_ONE;
    end else if (cmd.wr_lo) begin
      count_nxt = count_r + CNT_ONE;
    end else if (cmd.comp_last) begin
      count_nxt = wr_ptr_r + CNT_ONE;
    end else begin
      count_nxt = count_r;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (cmd.out_load) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
    out_nxt.status        = cmd.res;
    out_nxt.start_address = (cmd.res == ST_OK && req_r.opcode == OP_ALLOC) ?
                            ADDR_W'(hit_r.start) : '0;
  end

  always_comb begin
    sts.req_free = req_r.opcode == OP_FREE;
    sts.req_zero = req_r.alloc_size == '0;
    sts.fit      = fit;
    sts.exact    = CW'(hit_r.size) == CW'(req_r.alloc_size);
    sts.full     = count_r == CNT_MAX;
    sts.asc_done = !rvld_r && !asc_more;
    sts.dsc_done = !rvld_r && !dsc_more;
    sts.found    = found_r;
    sts.out_room = !out_vld_r || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_ent;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
      ridx_r  <= rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r   <= TOTAL_RST;
      count_r   <= CNT_ONE;
      rd_ptr_r  <= '0;
      wr_ptr_r  <= '0;
      rvld_r    <= 1'b0;
      acc_vld_r <= 1'b0;
      found_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      total_r   <= total_nxt;
      count_r   <= count_nxt;
      rd_ptr_r  <= rd_ptr_nxt;
      wr_ptr_r  <= wr_ptr_nxt;
      rvld_r    <= rd_en;
      acc_vld_r <= acc_vld_nxt;
      found_r   <= found_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (cmd.accept) begin
      req_r <= in_data;
    end
    if (hit_now) begin
      hit_r     <= rdata_r;
      hit_idx_r <= ridx_r;
    end
    if (cmd.out_load) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) && (count_r <= CNT_MAX))
    else $error("segment count out of range");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.seed || cmd.wr_lo || cmd.comp_last) |=> $stable(count_r))
    else $error("segment count changed without a table update");

  a_split_grow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_lo |=> count_r == $past(count_r) + CNT_ONE)
    else $error("split did not add one segment");

  a_merge_shrink: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.comp_last |=> count_r <= $past(count_r))
    else $error("merge pass grew the table");

  a_shift_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.shift_init |-> count_r < CNT_MAX)
    else $error("split started on a full table");

endmodule

### hw/rtl/first_fit_allocator_core.sv
`timescale 1ns / 1ps
// Top level of the first-fit address-range allocator with free-segment merging.
//
//   port group   dir  handshake           contents
//   in_*         in   in_valid/in_stall   request: opcode, alloc_size, address
//   out_*        out  out_valid/out_stall response: status, start_address
//   cfg_*        in   cfg_valid/cfg_ready total_memory, re-seeds the table
//
// Allocate: a scan for the first fitting entry, then either an exact fit or a tail shift
//   and a split; no fit, a full table and zero size end with their status. The scan and
//   the tail shift share one table read port.
// Free: one streaming read/merge/write pass over the table.
// Reset and each cfg write re-seed the table before the next request is taken.
// One response register: a new request is taken while it waits; the next response
//   waits until it drains.
module first_fit_allocator_core #(
  parameter int MAX_SEGMENTS = 64,
  parameter int ADDR_BITS    = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  ffa_pkg::req_t               in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output ffa_pkg::rsp_t               out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ffa_pkg::TOTAL_W-1:0] cfg_data
);
  import ffa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ffa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ffa_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .ADDR_BITS    (ADDR_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the first-fit allocator core: directed and random requests.
module tb;
  import ffa_pkg::*;

  localparam int SEGS        = 64;
  localparam int SPACE       = 65536;
  localparam int LIMIT       = 1000000;
  localparam int TAIL        = 150;
  localparam int HOLD_CYCLES = 1000;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  req_t                in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  rsp_t                out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [TOTAL_W-1:0]  cfg_data  = '0;

  // segment table as the block should hold it
  logic [ADDR_W-1:0]   seg_start_q [SEGS];
  logic [SIZE_W-1:0]   seg_size_q  [SEGS];
  logic                seg_free_q  [SEGS];
  int                  seg_count_q;

  rsp_t                rsp_expected_q [$];
  rsp_t                rsp_want;
  int                  errors      = 0;
  int                  cycle_count = 0;
  bit                  in_idle_on  = 1'b1;
  bit                  out_idle_on = 1'b1;
  bit                  valid_held  = 1'b0;
  bit                  hold_req    = 1'b0;
  bit                  hold_seen   = 1'b0;
  int                  hold_left   = 0;

  first_fit_allocator_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("first_fit_allocator_core: mismatch");
      $finish;
    end
  end

  function automatic void seed_segments(input logic [TOTAL_W-1:0] total);
    for (int k = 0; k < SEGS; k++) begin
      seg_start_q[k] = '0;
      seg_size_q[k]  = '0;
      seg_free_q[k]  = 1'b0;
    end
    seg_size_q[0]  = (total > SPACE) ? SIZE_W'(SPACE) : total;
    seg_free_q[0]  = 1'b1;
    seg_count_q    = 1;
  endfunction

  function automatic void merge_free_runs();
    int i;
    i = 0;
    while (i + 1 < seg_count_q) begin
      if (seg_free_q[i] && seg_free_q[i+1]) begin
        seg_size_q[i] = seg_size_q[i] + seg_size_q[i+1];
        for (int k = i + 1; k + 1 < seg_count_q; k++) begin
          seg_start_q[k] = seg_start_q[k+1];
          seg_size_q[k]  = seg_size_q[k+1];
          seg_free_q[k]  = seg_free_q[k+1];
        end
        seg_count_q--;
      end else begin
        i++;
      end
    end
  endfunction

  function automatic rsp_t predict_alloc(input logic [SIZE_W-1:0] size);
    rsp_t r;
    int   i;
    r.status        = ST_OK;
    r.start_address = '0;
    if (size == 0) begin
      r.status = ST_ZERO;
      return r;
    end
    i = 0;
    while (i < seg_count_q && !(seg_free_q[i] && seg_size_q[i] >= size)) i++;
    if (i >= seg_count_q) begin
      r.status = ST_NOFIT;
      return r;
    end
    if (seg_size_q[i] == size) begin
      seg_free_q[i]   = 1'b0;
      r.start_address = seg_start_q[i];
      return r;
    end
    if (seg_count_q >= SEGS) begin
      r.status = ST_FULL;
      return r;
    end
    for (int k = seg_count_q; k > i + 1; k--) begin
      seg_start_q[k] = seg_start_q[k-1];
      seg_size_q[k]  = seg_size_q[k-1];
      seg_free_q[k]  = seg_free_q[k-1];
    end
    seg_start_q[i+1] = seg_start_q[i] + ADDR_W'(size);
    seg_size_q[i+1]  = seg_size_q[i] - size;
    seg_free_q[i+1]  = 1'b1;
    seg_size_q[i]    = size;
    seg_free_q[i]    = 1'b0;
    seg_count_q++;
    r.start_address  = seg_start_q[i];
    return r;
  endfunction

  function automatic rsp_t predict_free(input logic [ADDR_W-1:0] addr);
    rsp_t r;
    r.status        = ST_NOADDR;
    r.start_address = '0;
    for (int i = 0; i < seg_count_q; i++) begin
      if (seg_start_q[i] == addr) begin
        seg_free_q[i] = 1'b1;
        merge_free_runs();
        r.status = ST_OK;
        return r;
      end
    end
    return r;
  endfunction

  function automatic rsp_t predict_response(input req_t r);
    if (r.opcode == OP_ALLOC) return predict_alloc(r.alloc_size);
    return predict_free(r.address);
  endfunction

  function automatic req_t alloc_req(input logic [SIZE_W-1:0] size);
    req_t r;
    r.opcode     = OP_ALLOC;
    r.alloc_size = size;
    r.address    = ADDR_W'($urandom);
    return r;
  endfunction

  function automatic req_t free_req(input logic [ADDR_W-1:0] addr);
    req_t r;
    r.opcode     = OP_FREE;
    r.alloc_size = SIZE_W'($urandom);
    r.address    = addr;
    return r;
  endfunction

  // mostly allocs and frees of live segments; the rest is noise
  function automatic req_t make_request(input int max_size);
    req_t r;
    int   pick;
    int   used [$];
    for (int i = 0; i < seg_count_q; i++) if (!seg_free_q[i]) used.insert(used.size(), i);
    pick = $urandom_range(99);
    if (pick < 50 || (pick < 85 && used.size() == 0)) begin
      r = alloc_req(SIZE_W'($urandom_range(max_size, 1)));
    end else if (pick < 85) begin
      r = free_req(seg_start_q[used[$urandom_range(used.size() - 1)]]);
    end else if (pick < 89) begin
      r = alloc_req('0);
    end else if (pick < 93) begin
      r = free_req(seg_start_q[$urandom_range(seg_count_q - 1)]);
    end else if (pick < 97) begin
      r = free_req(ADDR_W'($urandom));
    end else begin
      r = alloc_req(SIZE_W'($urandom));
    end
    return r;
  endfunction

  task automatic send_request(input req_t r);
    while (in_idle_on && $urandom_range(99) < 31) begin
      if (valid_held) begin
        in_valid   <= 1'b0;
        valid_held  = 1'b0;
      end
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_data    <= r;
    valid_held  = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    rsp_expected_q.insert(rsp_expected_q.size(), predict_response(r));
  endtask

  task automatic drain_responses();
    if (valid_held) begin
      in_valid   <= 1'b0;
      valid_held  = 1'b0;
    end
    while (rsp_expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_total_memory(input logic [TOTAL_W-1:0] total);
    drain_responses();
    cfg_valid <= 1'b1;
    cfg_data  <= total;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    seed_segments(total);
  endtask

  // check each response against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (rsp_expected_q.size() == 0) begin
        $display("%0t: response with none pending: expected none, actual status %0d addr %0h",
                 $time, out_data.status, out_data.start_address);
        errors++;
      end else begin
        rsp_want = rsp_expected_q.pop_front();
        if (out_data.status !== rsp_want.status) begin
          $display("%0t: status: expected %0d, actual %0d",
                   $time, rsp_want.status, out_data.status);
          errors++;
        end
        if (out_data.start_address !== rsp_want.start_address) begin
          $display("%0t: start_address: expected %0h, actual %0h",
                   $time, rsp_want.start_address, out_data.start_address);
          errors++;
        end
      end
    end
    out_stall <= (hold_left != 0) || (out_idle_on && $urandom_range(99) < 31);
  end

  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic test_reset_default();
    send_request(alloc_req(SIZE_W'(SPACE)));
    send_request(alloc_req(SIZE_W'(1)));
    send_request(alloc_req('0));
    send_request(free_req(16'h8000));
    send_request(free_req('0));
    send_request(alloc_req('1));
    send_request(alloc_req(SIZE_W'(1)));
    send_request(alloc_req(17'h07fff));
    send_request(free_req(16'h0001));
    send_request(free_req('0));
    send_request(free_req('0));
    send_request(free_req('1));
    drain_responses();
  endtask

  task automatic test_zero_total();
    write_total_memory('0);
    send_request(alloc_req(SIZE_W'(1)));
    send_request(alloc_req('0));
    send_request(free_req('0));
    repeat (10) send_request(make_request(4));
    drain_responses();
  endtask

  task automatic test_oversize_total();
    write_total_memory('1);
    send_request(alloc_req(SIZE_W'(SPACE)));
    send_request(free_req('0));
    write_total_memory(TOTAL_W'(1));
    send_request(alloc_req(SIZE_W'(1)));
    send_request(alloc_req(SIZE_W'(1)));
    drain_responses();
  endtask

  task automatic test_table_full();
    write_total_memory(TOTAL_W'(200));
    repeat (90) send_request(alloc_req(SIZE_W'($urandom_range(2, 1))));
    repeat (40) send_request(make_request(3));
    drain_responses();
  endtask

  task automatic test_random_mix(input logic [TOTAL_W-1:0] total, input int count,
                                 input int max_size, input bit idle);
    write_total_memory(total);
    in_idle_on   = idle;
    out_idle_on <= idle;
    repeat (count) send_request(make_request(max_size));
    drain_responses();
    in_idle_on   = 1'b1;
    out_idle_on <= 1'b1;
  endtask

  task automatic test_backpressure();
    write_total_memory(TOTAL_RST);
    in_idle_on  = 1'b0;
    hold_req   <= ~hold_req;
    repeat (20) send_request(make_request(512));
    drain_responses();
    in_idle_on  = 1'b1;
  endtask

  task automatic test_wide_sizes();
    write_total_memory('1);
    repeat (150) send_request(make_request(2048));
    repeat (3) send_request(alloc_req(SIZE_W'(SPACE)));
    repeat (100) send_request(make_request(16384));
    drain_responses();
  endtask

  initial begin
    seed_segments(TOTAL_RST);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_default();
    test_zero_total();
    test_oversize_total();
    test_table_full();
    test_random_mix(TOTAL_W'(300), 250, 8, 1'b1);
    test_random_mix(TOTAL_W'(4096), 300, 200, 1'b0);
    test_wide_sizes();
    test_random_mix(TOTAL_W'(1), 50, 1, 1'b1);
    test_random_mix(TOTAL_RST, 150, 4096, 1'b1);
    test_backpressure();
    drain_responses();
    repeat (TAIL) @(posedge clk);
    if (errors == 0 && rsp_expected_q.size() == 0) begin
      $display("first_fit_allocator_core: match");
    end else begin
      $display("first_fit_allocator_core: mismatch");
    end
    $finish;
  end

endmodule
